[rtl/core/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache model.
// Holds line and row layouts, outcome and request-kind codes and register indexes.
// No dependencies.
package salc_pkg;

   // Sizing
   localparam int MAX_SET_BITS = 6;
   localparam int WAYS         = 8;
   localparam int ADDR_BITS    = 64;

   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
   localparam int SHIFT_W  = $clog2(64 + MAX_SET_BITS + 1);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int CNT_W    = $clog2(WAYS + 1);
   localparam int TAG_W    = ADDR_BITS;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

   // Port field widths
   localparam int KIND_W     = 2;
   localparam int ADDRESS_W  = 64;
   localparam int OUTCOME_W  = 2;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int SETB_W     = 3;
   localparam int WAYSU_W    = 4;
   localparam int BLKB_W     = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   // Result of one lookup: what to report and the row to write back
   typedef struct packed {
      outcome_type outcome;
      row_type     new_row;
   } upd_type;

endpackage

[rtl/core/salc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the per-set row store; no dependencies.
module salc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[rtl/core/salc_update.sv]
// Replacement and recency logic for one set: picks the hit, empty or victim way,
// ages the other lines and builds the row to write back. Depends on salc_pkg.
module salc_update (
   input  salc_pkg::row_type                row,
   input  logic [salc_pkg::WAYS-1:0]        hit_vec,
   input  logic [salc_pkg::WAYS-1:0]        used,
   input  logic [salc_pkg::TAG_W-1:0]       tag,
   output salc_pkg::upd_type                upd
);
   import salc_pkg::*;

   logic              any_hit;
   logic              have_empty;
   logic              have_victim;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  empty_way;
   logic [WAY_W-1:0]  victim_way;
   logic [RANK_W-1:0] victim_rank;
   logic [WAY_W-1:0]  sel;
   outcome_type       outcome;
   logic              thr_inf;
   logic [RANK_W-1:0] thr;
   row_type           new_row;

   assign any_hit = |hit_vec;

   // lowest-numbered matching way wins
   always_comb begin
      hit_way = '0;
      for (int v = WAYS - 1; v >= 0; v--) begin
         if (hit_vec[v]) begin
            hit_way = WAY_W'(v);
         end
      end
   end

   // highest-numbered invalid way; oldest valid way, lowest on a tie
   always_comb begin
      have_empty  = 1'b0;
      empty_way   = '0;
      have_victim = 1'b0;
      victim_way  = '0;
      victim_rank = '0;
      for (int v = 0; v < WAYS; v++) begin
         if (used[v] && !row[v].valid) begin
            have_empty = 1'b1;
            empty_way  = WAY_W'(v);
         end
         if (used[v] && row[v].valid && (!have_victim || row[v].rank > victim_rank)) begin
            have_victim = 1'b1;
            victim_way  = WAY_W'(v);
            victim_rank = row[v].rank;
         end
      end
   end

   always_comb begin
      if (any_hit) begin
         sel     = hit_way;
         outcome = OUT_HIT;
      end else if (have_empty) begin
         sel     = empty_way;
         outcome = OUT_FILL;
      end else begin
         sel     = victim_way;
         outcome = OUT_EVICT;
      end
   end

   assign thr_inf = !row[sel].valid;
   assign thr     = row[sel].rank;

   // age every newer line of the set, saturating at the oldest rank
   always_comb begin
      for (int v = 0; v < WAYS; v++) begin
         new_row[v] = row[v];
         if (used[v] && (WAY_W'(v) != sel) && row[v].valid &&
             (thr_inf || row[v].rank < thr) && (row[v].rank != RANK_MAX)) begin
            new_row[v].rank = row[v].rank + 1'b1;
         end
      end
      new_row[sel].valid = 1'b1;
      new_row[sel].tag   = tag;
      new_row[sel].rank  = '0;
   end

   assign upd = {outcome, new_row};

endmodule

[rtl/core/set_assoc_lru_cache_model.sv]
// Top level of the tag-only set-associative LRU cache model.
// Depends on salc_pkg, salc_ram (row store) and salc_update (replacement logic).
//
// Usage:
//   req_* carries one access (kind, address) under valid/ready. rsp_* returns each
//   result under valid/ready: outcome, last and the three running totals.
//   Load and store (and kind three) give one result; modify gives two, the load
//   outcome with last low, then a hit with last high.
//   csr_we/csr_index/csr_wdata write set_bits, ways_used and block_bits; write only
//   while no request is in flight.
// Flow: an accepted request's first result is registered with its write back
//   (set row read, tag compare, then update and write back).
// Overlap: a load or store may be accepted while the previous one writes back, set
//   by the read-compare-write loop on the single row memory; a request to the set
//   just written is forwarded. A modify blocks requests until its second result.
// Reset: synchronous, active high. Clears the totals, the per-set valid bits and
//   the registers to set_bits 4, ways_used 1, block_bits 4. No clearing pass.
// Stall: the result register holds while rsp_ready is low; one more request may
//   be accepted and looked up, then the block waits before writing back.
module set_assoc_lru_cache_model (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [salc_pkg::KIND_W-1:0]       req_kind,
   input  logic [salc_pkg::ADDRESS_W-1:0]    req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [salc_pkg::OUTCOME_W-1:0]    rsp_outcome,
   output logic                              rsp_last,
   output logic [salc_pkg::COUNT_W-1:0]      rsp_hit_count,
   output logic [salc_pkg::COUNT_W-1:0]      rsp_miss_count,
   output logic [salc_pkg::COUNT_W-1:0]      rsp_evict_count,
   input  logic                              csr_we,
   input  logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import salc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOK   = 4'b0010,
      S_WRITE  = 4'b0100,
      S_SECOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SETB_W-1:0]  set_bits_ff;
   logic [WAYSU_W-1:0] ways_used_ff;
   logic [BLKB_W-1:0]  block_bits_ff;

   logic [SB_W-1:0]      sb_eff;
   logic [CNT_W-1:0]     ways_eff;
   logic [WAYS-1:0]      used;
   logic [SHIFT_W-1:0]   tag_shift;
   logic [ADDR_BITS-1:0] addr;
   logic [ADDR_BITS-1:0] addr_blk;
   logic [SET_W:0]       set_mask_full;
   logic [SET_W-1:0]     set_calc;
   logic [TAG_W-1:0]     tag_calc;

   logic                 accept;
   logic                 write_go;
   logic                 load_first;
   logic                 load_second;

   logic                 mod_ff;
   logic [SET_W-1:0]     set_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic                 fwd_ff;
   row_type              fwd_row_ff;
   logic [NUM_SETS-1:0]  row_valid_ff;
   row_type              row_ff;
   logic [WAYS-1:0]      hit_vec_ff;

   logic [ROW_W-1:0]     ram_rdata;
   row_type              row_cur;
   logic                 ram_we;
   upd_type              upd;

   logic [COUNT_W-1:0]   hit_ff, hit_in;
   logic [COUNT_W-1:0]   miss_ff, miss_in;
   logic [COUNT_W-1:0]   evict_ff, evict_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic                 rsp_last_ff;
   logic [COUNT_W-1:0]   rsp_hit_ff;
   logic [COUNT_W-1:0]   rsp_miss_ff;
   logic [COUNT_W-1:0]   rsp_evict_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SETB_W'(4);
         ways_used_ff  <= WAYSU_W'(1);
         block_bits_ff <= BLKB_W'(4);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[SETB_W-1:0];
            CSR_WAYS_USED:  ways_used_ff  <= csr_wdata[WAYSU_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[BLKB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SB_W'(MAX_SET_BITS);
      end else begin
         sb_eff = SB_W'(set_bits_ff);
      end
      if (ways_used_ff == '0) begin
         ways_eff = CNT_W'(1);
      end else if (int'(ways_used_ff) > WAYS) begin
         ways_eff = CNT_W'(WAYS);
      end else begin
         ways_eff = CNT_W'(ways_used_ff);
      end
      for (int v = 0; v < WAYS; v++) begin
         used[v] = CNT_W'(v) < ways_eff;
      end
   end

   // ---------------- address split ----------------
   assign addr          = req_address[ADDR_BITS-1:0];
   assign addr_blk      = addr >> block_bits_ff;
   assign set_mask_full = ({{SET_W{1'b0}}, 1'b1} << sb_eff) - 1'b1;
   assign set_calc      = addr_blk[SET_W-1:0] & set_mask_full[SET_W-1:0];
   assign tag_shift     = SHIFT_W'(block_bits_ff) + SHIFT_W'(sb_eff);
   assign tag_calc      = addr >> tag_shift;

   // ---------------- handshake ----------------
   assign write_go    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE) ||
                        ((state_ff == S_WRITE) && write_go && !mod_ff);
   assign accept      = req_valid && req_ready;
   assign load_first  = (state_ff == S_WRITE) && write_go;
   assign load_second = (state_ff == S_SECOND) && write_go;
   assign ram_we      = load_first;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_WRITE;
         S_WRITE: begin
            if (write_go) begin
               if (mod_ff) begin
                  state_in = S_SECOND;
               end else if (accept) begin
                  state_in = S_LOOK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SECOND: begin
            if (write_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- request capture and forwarding ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         mod_ff     <= (req_kind == KIND_MODIFY);
         set_ff     <= set_calc;
         tag_ff     <= tag_calc;
         // same set written this edge: take the new row instead of the memory read
         fwd_ff     <= ram_we && (set_ff == set_calc);
         fwd_row_ff <= upd.new_row;
      end
   end

   salc_ram #(
      .DEPTH(NUM_SETS),
      .WIDTH(ROW_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (set_ff),
      .wdata (upd.new_row),
      .re    (accept),
      .raddr (set_calc),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ram_we) begin
         row_valid_ff[set_ff] <= 1'b1;
      end
   end

   // ---------------- compare stage ----------------
   assign row_cur = fwd_ff ? fwd_row_ff : row_type'(ram_rdata);

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         for (int v = 0; v < WAYS; v++) begin
            row_ff[v].valid <= row_valid_ff[set_ff] && row_cur[v].valid;
            row_ff[v].tag   <= row_cur[v].tag;
            row_ff[v].rank  <= row_cur[v].rank;
            hit_vec_ff[v]   <= used[v] && row_valid_ff[set_ff] && row_cur[v].valid &&
                               (row_cur[v].tag == tag_ff);
         end
      end
   end

   // ---------------- update stage ----------------
   salc_update u_update (
      .row     (row_ff),
      .hit_vec (hit_vec_ff),
      .used    (used),
      .tag     (tag_ff),
      .upd     (upd)
   );

   always_comb begin
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      evict_in = evict_ff;
      if ((load_second || (load_first && upd.outcome == OUT_HIT)) && hit_ff != COUNT_MAX) begin
         hit_in = hit_ff + 1'b1;
      end
      if (load_first && upd.outcome != OUT_HIT && miss_ff != COUNT_MAX) begin
         miss_in = miss_ff + 1'b1;
      end
      if (load_first && upd.outcome == OUT_EVICT && evict_ff != COUNT_MAX) begin
         evict_in = evict_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= '0;
         miss_ff  <= '0;
         evict_ff <= '0;
      end else begin
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         evict_ff <= evict_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = load_first || load_second || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_first || load_second) begin
         rsp_outcome_ff <= load_first ? upd.outcome : OUT_HIT;
         rsp_last_ff    <= load_first ? !mod_ff : 1'b1;
         rsp_hit_ff     <= hit_in;
         rsp_miss_ff    <= miss_in;
         rsp_evict_ff   <= evict_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_hit_count   = rsp_hit_ff;
   assign rsp_miss_count  = rsp_miss_ff;
   assign rsp_evict_count = rsp_evict_ff;

   // ---------------- assertions ----------------
   a_first_of_modify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == S_SECOND)
      else $error("first result of a modify without its second pending");

   a_second_is_hit: assert property (@(posedge clock) disable iff (reset)
      load_second |=> rsp_valid_ff && rsp_outcome_ff == OUT_HIT && rsp_last_ff)
      else $error("second result of a modify is not a final hit");

   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evict_ff <= miss_ff)
      else $error("eviction total exceeds miss total");

   a_hit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_ff >= $past(hit_ff))
      else $error("hit total decreased");

endmodule
